// ===== rtl/gtk_pkg.sv =====
// ----------------------------------------------------------------------------
// gtk_pkg: shared types and constants of the top-k winner selector
// Fixed field widths and the control group that drives every cell.
// ----------------------------------------------------------------------------
package gtk_pkg;

	// width of the winner count register
	localparam int WC_W   = 6;
	// width of the rank field on the result beat
	localparam int RANK_W = 5;

	// per-cycle command broadcast along the cell chain
	typedef struct packed {
		logic insert;   // an input beat is taken this cycle
		logic drain;    // shift the chain toward the output by one place
	} gtk_ctrl_t;

endpackage

// ===== rtl/gtk_if.sv =====
// ----------------------------------------------------------------------------
// gtk_if: stream channels of the top-k winner selector
// Valid/ready channels for column score beats and winner beats.
// ----------------------------------------------------------------------------
interface gtk_in_if #(
	parameter int IDX_W   = 12,
	parameter int SCORE_W = 32
);
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   column_index;
	logic [SCORE_W-1:0] score;
	logic               last_column;

	modport source (output valid, column_index, score, last_column, input ready);
	modport sink   (input valid, column_index, score, last_column, output ready);
endinterface

interface gtk_out_if import gtk_pkg::*; #(
	parameter int IDX_W   = 12,
	parameter int SCORE_W = 32
);
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   winner_index;
	logic [SCORE_W-1:0] winner_score;
	logic [RANK_W-1:0]  winner_rank;
	logic               last_winner;

	modport source (output valid, winner_index, winner_score, winner_rank, last_winner,
		input ready);
	modport sink   (input valid, winner_index, winner_score, winner_rank, last_winner,
		output ready);
endinterface

// ===== rtl/gtk_cell.sv =====
// ----------------------------------------------------------------------------
// gtk_cell: one place of the sorted winner list
// Compares the broadcast score with its own entry, takes the new entry or its
// upper neighbor's on insert, and takes its lower neighbor's on drain.
// ----------------------------------------------------------------------------
module gtk_cell import gtk_pkg::*; #(
	parameter int IDX_W   = 12,
	parameter int SCORE_W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gtk_ctrl_t          ctrl,
	input  logic               en,
	input  logic [SCORE_W-1:0] new_score,
	input  logic [IDX_W-1:0]   new_index,
	input  logic               prev_wins,
	input  logic               prev_valid,
	input  logic [SCORE_W-1:0] prev_score,
	input  logic [IDX_W-1:0]   prev_index,
	input  logic               next_valid,
	input  logic [SCORE_W-1:0] next_score,
	input  logic [IDX_W-1:0]   next_index,
	output logic               wins,
	output logic               valid,
	output logic [SCORE_W-1:0] score,
	output logic [IDX_W-1:0]   index
);

	logic               valid_q;
	logic [SCORE_W-1:0] score_q;
	logic [IDX_W-1:0]   index_q;

	// new entry belongs at or above this place (ties keep the earlier column)
	assign wins = !valid_q || (new_score > score_q);

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			if (!en) begin
				valid_q <= 1'b0;
			end else if (wins) begin
				valid_q <= prev_wins ? prev_valid : 1'b1;
			end
		end else if (ctrl.drain) begin
			valid_q <= next_valid;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (en && wins) begin
				if (prev_wins) begin
					score_q <= prev_score;
					index_q <= prev_index;
				end else begin
					score_q <= new_score;
					index_q <= new_index;
				end
			end
		end else if (ctrl.drain) begin
			score_q <= next_score;
			index_q <= next_index;
		end
	end

	assign valid = valid_q;
	assign score = score_q;
	assign index = index_q;

endmodule

// ===== rtl/global_top_k_winner_select_unit.sv =====
// ----------------------------------------------------------------------------
// global_top_k_winner_select_unit: streaming top-k column selector
// Keeps the best k column scores in a sorted chain of cells and emits them
// in rank order after the last column of a set.
// ----------------------------------------------------------------------------
// Score beats are taken one per cycle while the chain is not draining: every
// beat is inserted in the cycle it is taken by a row of MAX_WINNERS
// compare-and-shift cells, each comparing the broadcast score with its own
// entry. Entries at places k and above are dropped, and equal scores keep
// the earlier column ahead. After the beat marked last_column the input
// stalls while the chain shifts its n stored winners out, rank 0 first, one
// per cycle into the output register while the receiver keeps it free.
// winner_count is k (values above MAX_WINNERS act as MAX_WINNERS, zero selects
// nothing); write it only while the block is idle.
// ----------------------------------------------------------------------------
module global_top_k_winner_select_unit import gtk_pkg::*; #(
	parameter int MAX_WINNERS = 32,
	parameter int MAX_COLUMNS = 4096,
	parameter int SCORE_BITS  = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            winner_count_we,
	input  logic [WC_W-1:0] winner_count_wdata,
	gtk_in_if.sink          in_item,
	gtk_out_if.source       out_winner
);

	localparam int IDX_W = $clog2(MAX_COLUMNS);

	// chain taps: place 0 and place MAX_WINNERS+1 are tie-offs, cell i sits at i+1
	logic                  tap_wins  [MAX_WINNERS+2];
	logic                  tap_valid [MAX_WINNERS+2];
	logic [SCORE_BITS-1:0] tap_score [MAX_WINNERS+2];
	logic [IDX_W-1:0]      tap_index [MAX_WINNERS+2];
	logic [MAX_WINNERS-1:0] cell_en;
	logic [MAX_WINNERS-1:0] cell_vld;

	logic [WC_W-1:0]       winner_count_q;
	logic                  drain_q;
	logic [RANK_W-1:0]     rank_q;
	logic                  out_valid_q;
	logic [IDX_W-1:0]      out_index_q;
	logic [SCORE_BITS-1:0] out_score_q;
	logic [RANK_W-1:0]     out_rank_q;
	logic                  out_last_q;

	gtk_ctrl_t ctrl;
	logic      in_acc;
	logic      load;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			winner_count_q <= WC_W'(1);
		end else if (winner_count_we) begin
			winner_count_q <= winner_count_wdata;
		end
	end

	// handshake and chain commands
	assign in_item.ready = !drain_q;
	assign in_acc        = in_item.valid && !drain_q;
	assign load          = drain_q && (!out_valid_q || out_winner.ready);
	assign ctrl.insert   = in_acc;
	assign ctrl.drain    = load;

	// chain ends
	assign tap_wins[0]                = 1'b0;
	assign tap_valid[0]               = 1'b0;
	assign tap_score[0]               = '0;
	assign tap_index[0]               = '0;
	assign tap_wins[MAX_WINNERS+1]    = 1'b0;
	assign tap_valid[MAX_WINNERS+1]   = 1'b0;
	assign tap_score[MAX_WINNERS+1]   = '0;
	assign tap_index[MAX_WINNERS+1]   = '0;

	// cell row
	for (genvar i = 0; i < MAX_WINNERS; i++) begin : g_cell
		assign cell_en[i]  = (i < int'(winner_count_q));
		assign cell_vld[i] = tap_valid[i+1];

		gtk_cell #(
			.IDX_W   (IDX_W),
			.SCORE_W (SCORE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.en         (cell_en[i]),
			.new_score  (in_item.score),
			.new_index  (in_item.column_index),
			.prev_wins  (tap_wins[i]),
			.prev_valid (tap_valid[i]),
			.prev_score (tap_score[i]),
			.prev_index (tap_index[i]),
			.next_valid (tap_valid[i+2]),
			.next_score (tap_score[i+2]),
			.next_index (tap_index[i+2]),
			.wins       (tap_wins[i+1]),
			.valid      (tap_valid[i+1]),
			.score      (tap_score[i+1]),
			.index      (tap_index[i+1])
		);
	end

	// drain sequencing and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q     <= 1'b0;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc && in_item.last_column) begin
				drain_q <= 1'b1;
				rank_q  <= '0;
			end
			if (load) begin
				out_valid_q <= tap_valid[1];
				rank_q      <= rank_q + RANK_W'(1);
				if (!tap_valid[1]) begin
					drain_q <= 1'b0;
				end
			end else if (out_winner.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload: head of the chain
	always_ff @(posedge clk) begin
		if (load) begin
			out_index_q <= tap_index[1];
			out_score_q <= tap_score[1];
			out_rank_q  <= rank_q;
			out_last_q  <= !tap_valid[2];
		end
	end

	assign out_winner.valid        = out_valid_q;
	assign out_winner.winner_index = out_index_q;
	assign out_winner.winner_score = out_score_q;
	assign out_winner.winner_rank  = out_rank_q;
	assign out_winner.last_winner  = out_last_q;

	// stored entries always form a prefix of the chain
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_vld + MAX_WINNERS'(1)) & cell_vld) == '0)
		else $error("cell occupancy is not a prefix");

	// no entry is kept at or beyond place k after an insert
	a_k_limit: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !winner_count_we |=> (cell_vld & ~cell_en) == '0)
		else $error("entry kept beyond winner count");

	// the final winner leaves an empty chain behind it
	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> !tap_valid[1])
		else $error("entries left after last winner");

	// no input beat is taken while winners are being shifted out
	a_no_insert_drain: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !ctrl.insert)
		else $error("insert during drain");

endmodule

// ===== verif/tb_global_top_k_winner_select_unit.sv =====
// ----------------------------------------------------------------------------
// tb_global_top_k_winner_select_unit: self-checking bench of the top-k selector
// Streams sets of column score beats through the block and predicts the sorted
// winner list of each set. Every winner beat is compared field by field with
// the oldest predicted winner. Covers tie order, zero and saturated winner
// counts, short sets, mid-set count changes, and output back-pressure.
// ----------------------------------------------------------------------------
module tb_global_top_k_winner_select_unit;
	import gtk_pkg::*;

	localparam int MAX_WINNERS  = 32;
	localparam int IDX_W        = 12;
	localparam int SCORE_W      = 32;
	// a full set drains MAX_WINNERS beats plus the output register
	localparam int DRAIN_WAIT   = MAX_WINNERS + 8;
	localparam int LIMIT_CYCLES = 500000;

	// Predicts winner beats from accepted column beats and checks the block's output.
	class winner_scoreboard;
		typedef struct {
			bit [IDX_W-1:0]   idx;
			bit [SCORE_W-1:0] score;
			bit [RANK_W-1:0]  rank;
			bit               last;
		} winner_t;

		bit [SCORE_W-1:0] kept_score [MAX_WINNERS];
		bit [IDX_W-1:0]   kept_idx [MAX_WINNERS];
		int unsigned      fill;
		bit [WC_W-1:0]    k_reg;
		winner_t          pending_q [$];
		int unsigned      errors;

		function new();
			fill   = 0;
			k_reg  = 1;
			errors = 0;
		endfunction

		function void set_k(bit [WC_W-1:0] value);
			k_reg = value;
		endfunction

		// Insert one column into the sorted list; queue the winners on the last column.
		function void note_column(bit [IDX_W-1:0] idx, bit [SCORE_W-1:0] sc, bit last);
			int unsigned k;
			int unsigned pos;
			int unsigned i;
			winner_t     w;
			k = (k_reg > MAX_WINNERS) ? MAX_WINNERS : k_reg;
			// trim the list when the count was lowered mid-set
			if (fill > k)
				fill = k;
			if (k != 0 && !(fill >= k && sc <= kept_score[k-1])) begin
				pos = 0;
				// equal scores stay ahead of the new column
				while (pos < fill && sc <= kept_score[pos])
					pos++;
				for (i = (fill < k) ? fill : k - 1; i > pos; i--) begin
					kept_score[i] = kept_score[i-1];
					kept_idx[i]   = kept_idx[i-1];
				end
				kept_score[pos] = sc;
				kept_idx[pos]   = idx;
				if (fill < k)
					fill++;
			end
			if (last) begin
				for (i = 0; i < fill; i++) begin
					w.idx   = kept_idx[i];
					w.score = kept_score[i];
					w.rank  = RANK_W'(i);
					w.last  = (i + 1 == fill);
					pending_q.insert(pending_q.size(), w);
				end
				fill = 0;
			end
		endfunction

		task report_mismatch(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		// Compare one winner beat with the oldest prediction.
		task check_winner(bit [IDX_W-1:0] idx, bit [SCORE_W-1:0] sc, bit [RANK_W-1:0] rank,
			bit last);
			winner_t w;
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("winner beat idx %0d score %h rank %0d with none pending",
					idx, sc, rank));
				return;
			end
			w = pending_q.pop_front();
			if (idx != w.idx)
				report_mismatch($sformatf("rank %0d: winner_index %0d, predicted %0d",
					w.rank, idx, w.idx));
			if (sc != w.score)
				report_mismatch($sformatf("rank %0d: winner_score %h, predicted %h",
					w.rank, sc, w.score));
			if (rank != w.rank)
				report_mismatch($sformatf("winner_rank %0d, predicted %0d", rank, w.rank));
			if (last != w.last)
				report_mismatch($sformatf("rank %0d: last_winner %0b, predicted %0b",
					w.rank, last, w.last));
		endtask

		task check_leftover();
			if (pending_q.size() != 0)
				report_mismatch($sformatf("%0d predicted winner beats never arrived",
					pending_q.size()));
		endtask
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	logic            winner_count_we;
	logic [WC_W-1:0] winner_count_wdata;

	gtk_in_if  #(.IDX_W(IDX_W), .SCORE_W(SCORE_W)) in_ch ();
	gtk_out_if #(.IDX_W(IDX_W), .SCORE_W(SCORE_W)) out_ch ();

	global_top_k_winner_select_unit #(
		.MAX_WINNERS(MAX_WINNERS),
		.MAX_COLUMNS(4096),
		.SCORE_BITS(SCORE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.winner_count_we(winner_count_we),
		.winner_count_wdata(winner_count_wdata),
		.in_item(in_ch),
		.out_winner(out_ch)
	);

	winner_scoreboard sb;
	int unsigned      send_idle_pct = 0;
	int unsigned      recv_idle_pct = 0;
	int unsigned      recv_hold_cycles = 0;
	int unsigned      cycle_count = 0;
	int unsigned      items_sent = 0;

	always #2 clk = ~clk;

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Drive ready: hold off for a requested stretch, else stall at random.
	always @(negedge clk) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else if (recv_hold_cycles != 0) begin
			out_ch.ready <= 1'b0;
			recv_hold_cycles <= recv_hold_cycles - 1;
		end else
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Check every accepted winner beat.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_winner(out_ch.winner_index, out_ch.winner_score, out_ch.winner_rank,
				out_ch.last_winner);
	end

	// Offer one column beat and hold it until it is taken; call at a falling edge.
	task automatic send_column(bit [IDX_W-1:0] idx, bit [SCORE_W-1:0] sc, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.column_index <= idx;
		in_ch.score        <= sc;
		in_ch.last_column  <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_column(idx, sc, last);
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted winner has come out.
	task automatic wait_drained(int unsigned extra);
		in_ch.valid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// Write the winner count; the block must be idle.
	task automatic write_k(bit [WC_W-1:0] value);
		winner_count_we    <= 1'b1;
		winner_count_wdata <= value;
		@(negedge clk);
		winner_count_we    <= 1'b0;
		sb.set_k(value);
	endtask

	function automatic bit [SCORE_W-1:0] random_score();
		int unsigned pick;
		pick = $urandom_range(9);
		// small scores give frequent ties
		if (pick < 3)
			return SCORE_W'($urandom_range(15));
		else if (pick == 3)
			return {SCORE_W{1'b1}};
		else
			return SCORE_W'($urandom);
	endfunction

	// Random sets of columns, with the winner count changed now and then between sets.
	task automatic run_phase(int unsigned n_items, int unsigned s_pct, int unsigned r_pct);
		int unsigned start;
		int unsigned set_len;
		int unsigned pick;
		int unsigned i;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		start = items_sent;
		while (items_sent - start < n_items) begin
			if ($urandom_range(2) == 0) begin
				wait_drained(DRAIN_WAIT);
				pick = $urandom_range(9);
				case (pick)
					0: write_k(0);
					1: write_k(1);
					2: write_k(WC_W'(MAX_WINNERS));
					3: write_k({WC_W{1'b1}});
					4: write_k(WC_W'($urandom_range(MAX_WINNERS + 1, 63)));
					default: write_k(WC_W'($urandom_range(2, MAX_WINNERS - 1)));
				endcase
			end
			pick = $urandom_range(19);
			if (pick < 15)
				set_len = $urandom_range(1, 12);
			else if (pick < 19)
				set_len = $urandom_range(13, 40);
			else
				set_len = $urandom_range(41, 70);
			for (i = 0; i < set_len; i++)
				send_column(IDX_W'($urandom_range(4095)), random_score(), i == set_len - 1);
		end
	endtask

	initial begin
		int unsigned s;
		int unsigned i;
		sb = new();
		arst_n             = 1'b0;
		winner_count_we    = 1'b0;
		winner_count_wdata = '0;
		in_ch.valid        = 1'b0;
		in_ch.column_index = '0;
		in_ch.score        = '0;
		in_ch.last_column  = 1'b0;
		out_ch.ready       = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset count of one: a tie at the top keeps the earlier column
		send_column(0, 0, 1'b0);
		send_column(12'hFFF, 32'hFFFF_FFFF, 1'b0);
		send_column(5, 32'hFFFF_FFFF, 1'b1);
		wait_drained(DRAIN_WAIT);

		// zero count: the last column yields nothing
		write_k(0);
		send_column(1, 55, 1'b0);
		send_column(2, 66, 1'b1);
		wait_drained(DRAIN_WAIT);

		// count above the cell row saturates; a short set emits only what it holds
		write_k({WC_W{1'b1}});
		send_column(7, 100, 1'b0);
		send_column(8, 100, 1'b0);
		send_column(9, 0, 1'b1);
		wait_drained(DRAIN_WAIT);

		// lower the count mid-set: entries past the new count are lost
		write_k(4);
		send_column(10, 10, 1'b0);
		send_column(11, 20, 1'b0);
		send_column(12, 30, 1'b0);
		send_column(13, 40, 1'b0);
		wait_drained(DRAIN_WAIT);
		write_k(2);
		send_column(14, 5, 1'b1);
		wait_drained(DRAIN_WAIT);

		// raise the count mid-set: dropped entries stay gone
		send_column(15, 100, 1'b0);
		send_column(16, 200, 1'b0);
		send_column(17, 300, 1'b0);
		wait_drained(DRAIN_WAIT);
		write_k(3);
		send_column(18, 50, 1'b1);
		wait_drained(DRAIN_WAIT);

		run_phase(160, 21, 79);
		run_phase(160, 79, 21);

		// hold the receiver off while sets of 24 columns keep coming, so the input stalls
		wait_drained(DRAIN_WAIT);
		write_k(WC_W'(MAX_WINNERS));
		send_idle_pct    = 0;
		recv_idle_pct    = 0;
		recv_hold_cycles = 300;
		for (s = 0; s < 3; s++)
			for (i = 0; i < 24; i++)
				send_column(IDX_W'($urandom_range(4095)), random_score(), i == 23);
		wait_drained(DRAIN_WAIT);

		run_phase(90, 0, 0);

		wait_drained(DRAIN_WAIT);
		sb.check_leftover();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/gtk_pkg.sv
rtl/gtk_if.sv
rtl/gtk_cell.sv
rtl/global_top_k_winner_select_unit.sv
verif/tb_global_top_k_winner_select_unit.sv
